// ===== design/assert_macros.svh =====
// Assertion helpers shared by the scan and replay design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/jrr_pkg.sv =====
package jrr_pkg;

  localparam int MaxPending = 64;
  localparam int MaxCommits = 32;
  localparam int PendAw = $clog2(MaxPending);
  localparam int CommAw = $clog2(MaxCommits);
  localparam int PendCw = PendAw + 1;
  localparam int CommCw = CommAw + 1;
  localparam int TotalW = 6;

  localparam logic [2:0] RegLogBase = 3'd0;
  localparam logic [2:0] RegLogUsed = 3'd1;
  localparam logic [2:0] RegMagic = 3'd2;
  localparam logic [2:0] RegBegin = 3'd3;
  localparam logic [2:0] RegBlockWrite = 3'd4;
  localparam logic [2:0] RegCommit = 3'd5;
  localparam logic [2:0] RegCheckpoint = 3'd6;

  localparam logic ReqStart = 1'b0;

  localparam logic [1:0] KindFetch = 2'd0;
  localparam logic [1:0] KindCopy = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [15:0] hdr_magic;
    logic [15:0] hdr_kind;
    logic [31:0] hdr_txn;
    logic [31:0] hdr_lba;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [31:0] fetch_sector;
    logic [31:0] copy_source;
    logic [31:0] copy_dest;
    logic [5:0]  commit_total;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] log_base;
    logic [15:0] log_used;
    logic [15:0] record_magic;
    logic [15:0] code_begin;
    logic [15:0] code_block_write;
    logic [15:0] code_commit;
    logic [15:0] code_checkpoint;
  } cfg_t;

  // Work handed from the scanner to the replay unit.
  typedef struct packed {
    logic        fetch;
    logic [16:0] scan_index;
    logic        finish;
  } job_t;

endpackage

// ===== design/jrr_scan.sv =====
`include "assert_macros.svh"

module jrr_scan (
  input  logic              clk,
  input  logic              rst,
  input  jrr_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  jrr_pkg::in_item_t item,
  output logic              job_valid,
  input  logic              job_ready,
  output jrr_pkg::job_t     job,
  input  logic              back_busy,
  output logic              pend_we,
  output logic [jrr_pkg::PendAw-1:0] pend_waddr,
  output logic [31:0]       pend_wtxn,
  output logic [31:0]       pend_wlba,
  output logic [16:0]       pend_wsrc,
  output logic              comm_we,
  output logic [jrr_pkg::CommAw-1:0] comm_waddr,
  output logic [31:0]       comm_wid,
  output logic [jrr_pkg::PendCw-1:0] pending_count,
  output logic [jrr_pkg::CommCw-1:0] commit_count
);

  logic        scanning;
  logic [16:0] scan_index;
  logic [31:0] open_txn;
  logic        take;
  logic [16:0] idx1, idx_next;
  logic        is_begin, is_bw, is_commit, is_ckpt;
  logic        hdr_ok;

  // One item in flight: the front waits until its job has left and the back is idle.
  assign full = job_valid || back_busy;
  assign take = push && !full;

  assign is_begin = item.hdr_kind == cfg.code_begin;
  assign is_bw = !is_begin && item.hdr_kind == cfg.code_block_write;
  assign is_commit = !is_begin && !is_bw && item.hdr_kind == cfg.code_commit;
  assign is_ckpt = !is_begin && !is_bw && !is_commit &&
                   item.hdr_kind == cfg.code_checkpoint;
  assign idx1 = scan_index + 17'd1;
  assign idx_next = is_bw ? idx1 + 17'd1 : idx1;

  assign hdr_ok = take && item.req_type != jrr_pkg::ReqStart && scanning &&
                  item.hdr_magic == cfg.record_magic;

  assign pend_we = hdr_ok && is_bw && pending_count < jrr_pkg::PendCw'(jrr_pkg::MaxPending);
  assign pend_waddr = pending_count[jrr_pkg::PendAw-1:0];
  assign pend_wtxn = open_txn;
  assign pend_wlba = item.hdr_lba;
  assign pend_wsrc = idx1;
  assign comm_we = hdr_ok && is_commit &&
                   commit_count < jrr_pkg::CommCw'(jrr_pkg::MaxCommits);
  assign comm_waddr = commit_count[jrr_pkg::CommAw-1:0];
  assign comm_wid = item.hdr_txn;

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      scan_index <= '0;
      open_txn <= '0;
      pending_count <= '0;
      commit_count <= '0;
      job_valid <= 1'b0;
      job <= '0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (take) begin
        if (item.req_type == jrr_pkg::ReqStart) begin
          scan_index <= '0;
          open_txn <= '0;
          pending_count <= '0;
          commit_count <= '0;
          job_valid <= 1'b1;
          if (cfg.log_used != 16'd0) begin
            scanning <= 1'b1;
            job <= '{fetch: 1'b1, scan_index: '0, finish: 1'b0};
          end else begin
            scanning <= 1'b0;
            job <= '{fetch: 1'b0, scan_index: '0, finish: 1'b1};
          end
        end else if (scanning) begin
          job_valid <= 1'b1;
          if (item.hdr_magic != cfg.record_magic) begin
            scanning <= 1'b0;
            job <= '{fetch: 1'b0, scan_index: scan_index, finish: 1'b1};
          end else begin
            scan_index <= idx_next;
            if (is_begin) open_txn <= item.hdr_txn;
            if (pend_we) pending_count <= pending_count + 1'b1;
            if (comm_we) commit_count <= commit_count + 1'b1;
            if (is_ckpt) pending_count <= '0;
            if (idx_next < {1'b0, cfg.log_used}) begin
              job <= '{fetch: 1'b1, scan_index: idx_next, finish: 1'b0};
            end else begin
              scanning <= 1'b0;
              job <= '{fetch: 1'b0, scan_index: idx_next, finish: 1'b1};
            end
          end
        end
      end
    end
  end

  `ASSERT_NEXT(a_take_job, clk, rst, take && scanning, job_valid)
  `ASSERT_IMPL(a_full_job, clk, rst, job_valid, full)
  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1,
               pending_count <= jrr_pkg::PendCw'(jrr_pkg::MaxPending))

endmodule

// ===== design/jrr_replay.sv =====
`include "assert_macros.svh"

module jrr_replay (
  input  logic              clk,
  input  logic              rst,
  input  jrr_pkg::cfg_t     cfg,
  input  logic              job_valid,
  output logic              job_ready,
  input  jrr_pkg::job_t     job,
  output logic              busy,
  input  logic              pend_we,
  input  logic [jrr_pkg::PendAw-1:0] pend_waddr,
  input  logic [31:0]       pend_wtxn,
  input  logic [31:0]       pend_wlba,
  input  logic [16:0]       pend_wsrc,
  input  logic              comm_we,
  input  logic [jrr_pkg::CommAw-1:0] comm_waddr,
  input  logic [31:0]       comm_wid,
  input  logic [jrr_pkg::PendCw-1:0] pending_count,
  input  logic [jrr_pkg::CommCw-1:0] commit_count,
  output logic              empty,
  input  logic              pop,
  output jrr_pkg::out_item_t result
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREAD = 5'b00010,
    S_CMP   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] pend_txn_mem [jrr_pkg::MaxPending];
  logic [31:0] pend_lba_mem [jrr_pkg::MaxPending];
  logic [16:0] pend_src_mem [jrr_pkg::MaxPending];
  logic [31:0] comm_mem [jrr_pkg::MaxCommits];

  logic [jrr_pkg::PendCw-1:0] pi;
  logic [jrr_pkg::CommCw-1:0] ci;
  logic [jrr_pkg::CommAw-1:0] ci_rd;
  logic [31:0] cur_txn, cur_lba, cid;
  logic [16:0] cur_src;
  logic        found;
  logic        held_valid;
  jrr_pkg::out_item_t held;
  logic [5:0]  total;
  logic        slot_free, load;
  logic        stage_v;
  logic [31:0] stage_src, stage_dst;

  assign total = 6'(commit_count);
  assign busy = state != S_IDLE;
  assign empty = !held_valid;
  assign result = held;
  assign job_ready = state == S_IDLE && !held_valid;
  assign slot_free = !held_valid || pop;
  assign load = (state == S_IDLE && job_valid && !held_valid && job.fetch) ||
                (state == S_EMIT && stage_v && slot_free) ||
                (state == S_DONE && slot_free);

  // The compare loop reads one id ahead so that cid holds the id at ci.
  assign ci_rd = (state == S_CMP) ? ci[jrr_pkg::CommAw-1:0] + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_txn_mem[pend_waddr] <= pend_wtxn;
      pend_lba_mem[pend_waddr] <= pend_wlba;
      pend_src_mem[pend_waddr] <= pend_wsrc;
    end
    if (comm_we) comm_mem[comm_waddr] <= comm_wid;
    cur_txn <= pend_txn_mem[pi[jrr_pkg::PendAw-1:0]];
    cur_lba <= pend_lba_mem[pi[jrr_pkg::PendAw-1:0]];
    cur_src <= pend_src_mem[pi[jrr_pkg::PendAw-1:0]];
    cid <= comm_mem[ci_rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held_valid <= 1'b0;
      pi <= '0;
      ci <= '0;
      found <= 1'b0;
      stage_v <= 1'b0;
    end else begin
      held_valid <= load || (held_valid && !pop);
      case (state)
        S_IDLE: begin
          if (job_valid && !held_valid) begin
            if (job.fetch) begin
              held <= '{out_kind: jrr_pkg::KindFetch,
                        fetch_sector: cfg.log_base + 32'(job.scan_index),
                        copy_source: '0, copy_dest: '0, commit_total: '0,
                        run_last: 1'b0};
            end else begin
              pi <= '0;
              stage_v <= 1'b0;
              state <= S_PREAD;
            end
          end
        end
        S_PREAD: begin
          // Memory reads for entry pi and commit id 0 land next cycle.
          if (pi >= pending_count) begin
            state <= S_DONE;
          end else begin
            ci <= '0;
            found <= 1'b0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (found) begin
            state <= S_EMIT;
          end else if (ci == commit_count) begin
            pi <= pi + 1'b1;
            state <= S_PREAD;
          end else begin
            found <= cid == cur_txn;
            ci <= ci + 1'b1;
          end
        end
        S_EMIT: begin
          // A copy waits in the stage until the next one, or the end, is known.
          if (!stage_v || slot_free) begin
            if (stage_v) begin
              held <= '{out_kind: jrr_pkg::KindCopy, fetch_sector: '0,
                        copy_source: stage_src, copy_dest: stage_dst,
                        commit_total: total, run_last: 1'b0};
            end
            stage_src <= cfg.log_base + 32'(cur_src);
            stage_dst <= cur_lba;
            stage_v <= 1'b1;
            pi <= pi + 1'b1;
            state <= S_PREAD;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            if (stage_v) begin
              held <= '{out_kind: jrr_pkg::KindCopy, fetch_sector: '0,
                        copy_source: stage_src, copy_dest: stage_dst,
                        commit_total: total, run_last: 1'b1};
            end else begin
              held <= '{out_kind: jrr_pkg::KindDone, fetch_sector: '0,
                        copy_source: '0, copy_dest: '0, commit_total: total,
                        run_last: 1'b1};
            end
            stage_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_onehot, clk, rst, 1'b1, $onehot(state))
  `ASSERT_IMPL(a_ready_idle, clk, rst, job_ready, state == S_IDLE)
  `ASSERT_NEXT(a_done_out, clk, rst, state == S_DONE && !held_valid, !empty)

endmodule

// ===== design/journal_redo_recovery.sv =====
// Channel   Handshake          Payload
// input     push / full        in_item  (jrr_pkg::in_item_t)
// result    empty / pop        out_item (jrr_pkg::out_item_t)
// config    cfg_we             cfg_index, cfg_data
// A header's fetch result moves from the scan job register to the result register.
// At the end of a scan each pending write is compared with the committed list one id a
// cycle; a match is staged as a copy, and a done state closes the run.
// Each copy waits in a stage so the last can carry run_last; a held result stalls replay.
// Only one item is in flight; full stays high until its results have left.
// Reset is synchronous and clears all control state.
module journal_redo_recovery (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  jrr_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output jrr_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  jrr_pkg::cfg_t cfg;
  logic job_valid, job_ready, back_busy, pend_we, comm_we;
  jrr_pkg::job_t job;
  logic [jrr_pkg::PendAw-1:0] pend_waddr;
  logic [jrr_pkg::CommAw-1:0] comm_waddr;
  logic [31:0] pend_wtxn, pend_wlba, comm_wid;
  logic [16:0] pend_wsrc;
  logic [jrr_pkg::PendCw-1:0] pending_count;
  logic [jrr_pkg::CommCw-1:0] commit_count;
  logic front_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{log_base: '0, log_used: '0, record_magic: '0, code_begin: 16'd1,
               code_block_write: 16'd2, code_commit: 16'd3, code_checkpoint: 16'd4};
    end else if (cfg_we) begin
      case (cfg_index)
        jrr_pkg::RegLogBase:    cfg.log_base <= cfg_data;
        jrr_pkg::RegLogUsed:    cfg.log_used <= cfg_data[15:0];
        jrr_pkg::RegMagic:      cfg.record_magic <= cfg_data[15:0];
        jrr_pkg::RegBegin:      cfg.code_begin <= cfg_data[15:0];
        jrr_pkg::RegBlockWrite: cfg.code_block_write <= cfg_data[15:0];
        jrr_pkg::RegCommit:     cfg.code_commit <= cfg_data[15:0];
        jrr_pkg::RegCheckpoint: cfg.code_checkpoint <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The front also waits for the result register to drain.
  assign full = front_full || !empty;

  jrr_scan u_scan (
    .clk, .rst, .cfg, .push(push && empty), .full(front_full), .item(in_item),
    .job_valid, .job_ready, .job, .back_busy, .pend_we, .pend_waddr,
    .pend_wtxn, .pend_wlba, .pend_wsrc, .comm_we, .comm_waddr, .comm_wid,
    .pending_count, .commit_count
  );

  jrr_replay u_replay (
    .clk, .rst, .cfg, .job_valid, .job_ready, .job, .busy(back_busy),
    .pend_we, .pend_waddr, .pend_wtxn, .pend_wlba, .pend_wsrc, .comm_we,
    .comm_waddr, .comm_wid, .pending_count, .commit_count, .empty, .pop,
    .result(out_item)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 3000;
  localparam int RandomItems = 280;

  logic clk;
  logic rst;
  logic push;
  logic full;
  jrr_pkg::in_item_t in_item;
  logic empty;
  logic pop;
  jrr_pkg::out_item_t out_item;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  journal_redo_recovery uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Shadow copy of the recovery engine.
  jrr_pkg::cfg_t model_cfg;
  logic scanning;
  logic [16:0] scan_pos;
  logic [31:0] active_id;
  logic [31:0] pend_txn [jrr_pkg::MaxPending];
  logic [31:0] pend_lba [jrr_pkg::MaxPending];
  logic [16:0] pend_src [jrr_pkg::MaxPending];
  int pend_n;
  logic [31:0] committed_ids [jrr_pkg::MaxCommits];
  int commit_n;

  jrr_pkg::out_item_t replay_expect_q [$];
  int mismatches;
  int burst_left;
  int idle_cycles;
  int cycle_no;
  int stall_mode;

  task automatic emit_replay();
    int n;
    logic hit;
    jrr_pkg::out_item_t r;
    n = 0;
    for (int i = 0; i < pend_n; i++) begin
      hit = 1'b0;
      for (int c = 0; c < commit_n; c++) begin
        if (committed_ids[c] == pend_txn[i]) hit = 1'b1;
      end
      if (hit) begin
        r = '0;
        r.out_kind = jrr_pkg::KindCopy;
        r.copy_source = model_cfg.log_base + {15'd0, pend_src[i]};
        r.copy_dest = pend_lba[i];
        r.commit_total = commit_n[5:0];
        replay_expect_q.push_back(r);
        n++;
      end
    end
    if (n == 0) begin
      r = '0;
      r.out_kind = jrr_pkg::KindDone;
      r.commit_total = commit_n[5:0];
      r.run_last = 1'b1;
      replay_expect_q.push_back(r);
    end else begin
      replay_expect_q[replay_expect_q.size() - 1].run_last = 1'b1;
    end
    scanning = 1'b0;
  endtask

  task automatic fetch_or_replay();
    jrr_pkg::out_item_t r;
    if (scan_pos < {1'b0, model_cfg.log_used}) begin
      r = '0;
      r.out_kind = jrr_pkg::KindFetch;
      r.fetch_sector = model_cfg.log_base + {15'd0, scan_pos};
      replay_expect_q.push_back(r);
    end else begin
      emit_replay();
    end
  endtask

  task automatic predict_recovery(jrr_pkg::in_item_t it);
    if (it.req_type == jrr_pkg::ReqStart) begin
      scanning = 1'b1;
      scan_pos = '0;
      active_id = '0;
      pend_n = 0;
      commit_n = 0;
      fetch_or_replay();
    end else if (scanning) begin
      if (it.hdr_magic != model_cfg.record_magic) begin
        emit_replay();
      end else begin
        scan_pos = scan_pos + 17'd1;
        if (it.hdr_kind == model_cfg.code_begin) begin
          active_id = it.hdr_txn;
        end else if (it.hdr_kind == model_cfg.code_block_write) begin
          if (pend_n < jrr_pkg::MaxPending) begin
            pend_txn[pend_n] = active_id;
            pend_lba[pend_n] = it.hdr_lba;
            pend_src[pend_n] = scan_pos;
            pend_n++;
          end
          scan_pos = scan_pos + 17'd1;
        end else if (it.hdr_kind == model_cfg.code_commit) begin
          if (commit_n < jrr_pkg::MaxCommits) begin
            committed_ids[commit_n] = it.hdr_txn;
            commit_n++;
          end
        end else if (it.hdr_kind == model_cfg.code_checkpoint) begin
          pend_n = 0;
        end
        fetch_or_replay();
      end
    end
  endtask

  // Sends one beat; the sender runs in bursts with random gaps between them.
  task automatic send_item(jrr_pkg::in_item_t it);
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_recovery(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_header(logic [15:0] magic, logic [15:0] kind, logic [31:0] txn,
                             logic [31:0] lba);
    jrr_pkg::in_item_t it;
    it.req_type = ~jrr_pkg::ReqStart;
    it.hdr_magic = magic;
    it.hdr_kind = kind;
    it.hdr_txn = txn;
    it.hdr_lba = lba;
    send_item(it);
  endtask

  task automatic send_start();
    jrr_pkg::in_item_t it;
    it.req_type = jrr_pkg::ReqStart;
    it.hdr_magic = 16'($urandom);
    it.hdr_kind = 16'($urandom);
    it.hdr_txn = $urandom;
    it.hdr_lba = $urandom;
    send_item(it);
  endtask

  // Waits until the block has drained, so that registers may be written.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (replay_expect_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_regs(jrr_pkg::cfg_t c);
    logic [31:0] vals [7];
    logic [2:0] idx [7];
    vals = '{c.log_base, {16'd0, c.log_used}, {16'd0, c.record_magic},
             {16'd0, c.code_begin}, {16'd0, c.code_block_write},
             {16'd0, c.code_commit}, {16'd0, c.code_checkpoint}};
    idx = '{jrr_pkg::RegLogBase, jrr_pkg::RegLogUsed, jrr_pkg::RegMagic,
            jrr_pkg::RegBegin, jrr_pkg::RegBlockWrite, jrr_pkg::RegCommit,
            jrr_pkg::RegCheckpoint};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    model_cfg = c;
  endtask

  task automatic test_directed();
    jrr_pkg::cfg_t c;
    drain();
    c = '{32'hFFFF_FFF0, 16'd24, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4};
    program_regs(c);
    send_header(16'hFFFF, 16'd1, 32'd5, 32'd0);      // header while idle
    send_start();
    send_header(16'hFFFF, 16'd1, 32'hFFFF_FFFF, 32'd0);
    send_header(16'hFFFF, 16'd2, 32'd0, 32'hFFFF_FFFF);
    send_header(16'hFFFF, 16'd2, 32'd0, 32'h0000_0000);
    send_header(16'hFFFF, 16'hBEEF, 32'd0, 32'd0);   // unknown type
    send_header(16'hFFFF, 16'd3, 32'hFFFF_FFFF, 32'd0);
    send_header(16'hFFFF, 16'd1, 32'd7, 32'd0);
    send_header(16'hFFFF, 16'd2, 32'd7, 32'h1234_5678);
    send_header(16'hFFFF, 16'd3, 32'd6, 32'd0);
    send_header(16'h0000, 16'd3, 32'd0, 32'd0);      // bad magic ends the scan
    send_start();
    send_header(16'hFFFF, 16'd2, 32'd0, 32'hAAAA_5555);
    send_header(16'hFFFF, 16'd4, 32'd0, 32'd0);      // checkpoint drops the write
    send_header(16'hFFFF, 16'd3, 32'd0, 32'd0);
    send_header(16'h7FFF, 16'd0, 32'd0, 32'd0);
    send_start();
    send_header(16'hFFFF, 16'd1, 32'd9, 32'd0);
    send_start();                                    // restart mid-scan
    send_header(16'hFFFF, 16'd3, 32'd0, 32'd0);
    send_header(16'hFFFE, 16'd3, 32'd0, 32'd0);
    drain();
    // Empty log, then a clash of all four codes with a two-sector log.
    c = '{32'h0, 16'd0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    program_regs(c);
    send_start();
    drain();
    c.log_used = 16'd2;
    program_regs(c);
    send_start();
    send_header(16'h0000, 16'hFFFF, 32'd0, 32'd1);
    send_header(16'h0000, 16'hFFFF, 32'd0, 32'd2);
    drain();
    // Block write landing at the log end.
    c = '{32'h8000_0000, 16'd3, 16'h5A5A, 16'd2, 16'd3, 16'd1, 16'd1};
    program_regs(c);
    send_start();
    send_header(16'h5A5A, 16'd1, 32'd0, 32'd0);      // commit of id 0
    send_header(16'h5A5A, 16'd0, 32'd0, 32'd0);      // unknown
    send_header(16'h5A5A, 16'd3, 32'd0, 32'hCAFE_0001);
  endtask

  // Fills the pending list and the committed list past their bounds.
  task automatic test_list_limits();
    jrr_pkg::cfg_t c;
    drain();
    c = '{32'd100, 16'd400, 16'h1357, 16'd10, 16'd20, 16'd30, 16'd40};
    program_regs(c);
    send_start();
    send_header(16'h1357, 16'd10, 32'd1, 32'd0);
    for (int i = 0; i < 70; i++) send_header(16'h1357, 16'd20, 32'd0, $urandom);
    for (int i = 0; i < 40; i++) send_header(16'h1357, 16'd30, 32'd40 - i, 32'd0);
    send_header(16'h1357, 16'd30, 32'd1, 32'd0);
    send_header(16'h0000, 16'd0, 32'd0, 32'd0);
    send_header(16'h1357, 16'd10, 32'd1, 32'd0);     // ignored once idle
  endtask

  task automatic test_random();
    jrr_pkg::cfg_t c;
    int sent;
    int phase_no;
    logic [15:0] kind;
    logic [31:0] txn;
    logic [15:0] magic;
    sent = 0;
    phase_no = 0;
    while (sent < RandomItems) begin
      drain();
      case (phase_no % 4)
        0: c = '{$urandom, 16'($urandom_range(8, 40)), 16'($urandom), 16'd1, 16'd2,
                 16'd3, 16'd4};
        1: c = '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom)};
        2: c = '{32'h0, 16'($urandom_range(1, 60)), 16'h0000, 16'hFFFF, 16'h0000,
                 16'h8000, 16'h7FFF};
        default: c = '{$urandom, 16'($urandom_range(4, 30)), 16'($urandom),
                       16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                       16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))};
      endcase
      program_regs(c);
      for (int r = 0; r < 6 && sent < RandomItems; r++) begin
        send_start();
        sent++;
        while (scanning && sent < RandomItems) begin
          case ($urandom_range(0, 9))
            0, 1, 2: kind = c.code_block_write;
            3, 4: kind = c.code_begin;
            5, 6: kind = c.code_commit;
            7: kind = c.code_checkpoint;
            default: kind = 16'($urandom);
          endcase
          txn = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 3);
          magic = ($urandom_range(0, 40) == 0) ? 16'($urandom) : c.record_magic;
          if ($urandom_range(0, 60) == 0) send_start();
          else send_header(magic, kind, txn, $urandom);
          sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_header(16'($urandom), 16'($urandom), $urandom, $urandom);
        end
      end
      phase_no++;
    end
  endtask

  // Result side: checks each beat and applies its own stall pattern.
  always @(posedge clk) begin
    jrr_pkg::out_item_t want;
    cycle_no <= cycle_no + 1;
    if (cycle_no % 256 == 0) stall_mode = $urandom_range(0, 2);
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (pop && !empty) begin
        if (replay_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", out_item);
        end else begin
          want = replay_expect_q.pop_front();
          if (out_item.out_kind !== want.out_kind ||
              out_item.fetch_sector !== want.fetch_sector ||
              out_item.copy_source !== want.copy_source ||
              out_item.copy_dest !== want.copy_dest ||
              out_item.commit_total !== want.commit_total ||
              out_item.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 1) == 0);
      default: pop <= ($urandom_range(0, 4) == 0);
    endcase
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    burst_left = 0;
    idle_cycles = 0;
    cycle_no = 0;
    stall_mode = 0;
    model_cfg = '{32'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 16'd4};
    scanning = 1'b0;
    scan_pos = '0;
    active_id = '0;
    pend_n = 0;
    commit_n = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_list_limits();
    test_random();
    drain();
    if (mismatches == 0 && replay_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== journal_redo_recovery.f =====
+incdir+design
design/jrr_pkg.sv
design/jrr_scan.sv
design/jrr_replay.sv
design/journal_redo_recovery.sv
test/testbench.sv
